### design/fat_block_chain_manager_top_assert.svh
// Assertion macros shared by the chain manager RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef FAT_BLOCK_CHAIN_MANAGER_TOP_ASSERT_SVH
`define FAT_BLOCK_CHAIN_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBCM_ASSERT_IMPL(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("fbcm assertion failed");

// Next-cycle implication, checked outside reset.
`define FBCM_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("fbcm assertion failed");

`endif

### design/fbcm_pkg.sv
// Shared types and constants of the FAT chain manager.
// No dependencies; used by the channel interfaces and the top level.
package fbcm_pkg;

  localparam int NUM_BLOCKS_DEF = 1024;

  // Payload field widths
  localparam int OP_W     = 2;
  localparam int BLOCK_W  = 10;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LOOPED   = 2'd3;

  // Link kinds for read-next
  localparam logic [KIND_W-1:0] LK_POINTER = 2'd0;
  localparam logic [KIND_W-1:0] LK_EOC     = 2'd1;
  localparam logic [KIND_W-1:0] LK_FREE    = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_ALLOC_LINK,
    S_FREE_RD,
    S_FREE_CHK,
    S_NEXT_RD,
    S_NEXT_CHK,
    S_RESP
  } state_t;

endpackage

### design/fbcm_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on fbcm_pkg for the field widths.
interface fbcm_in_if;
  logic                         valid;
  logic                         ready;
  logic [fbcm_pkg::OP_W-1:0]    op;
  logic [fbcm_pkg::BLOCK_W-1:0] block;
  logic                         has_block;

  modport source (output valid, op, block, has_block, input ready);
  modport sink   (input valid, op, block, has_block, output ready);
endinterface

interface fbcm_out_if;
  logic                          valid;
  logic                          ready;
  logic [fbcm_pkg::STATUS_W-1:0] status;
  logic [fbcm_pkg::BLOCK_W-1:0]  result_block;
  logic [fbcm_pkg::KIND_W-1:0]   link_kind;
  logic [fbcm_pkg::COUNT_W-1:0]  freed_count;

  modport source (output valid, status, result_block, link_kind, freed_count, input ready);
  modport sink   (input valid, status, result_block, link_kind, freed_count, output ready);
endinterface

### design/fat_block_chain_manager_top.sv
// FAT chain manager: one request channel (in_ch) and one result channel
// (out_ch), valid/ready; a transfer happens when both are high at a clock edge.
// Each request (allocate, free chain, read next) gives exactly one result.
// The table sits in one synchronous RAM of NUM_BLOCKS entries with a
// registered read; every table lookup is a read state plus a check state.
// After reset a clearing pass writes every entry free, one per cycle, so
// in_ch.ready stays low during reset and until that pass is done.
// Read next reads the given entry once; a bad block or an unused op goes
// straight to the result. Free chain reads and frees entries along the chain
// until it reads an end of chain or an entry that is already free. Allocate
// scans entries from the lowest-free hint, which moves past each allocated
// block and back down when a lower block is freed, and links a given tail to
// the new block unless the tail is that block; a full table gives no space.
// One request is in work at a time; the next one is taken as soon as the
// result is in the output register, even while out_ch is stalled. A stalled
// result holds its fields; a finished request then waits until it is taken.
// Depends on fbcm_pkg, fbcm_if.sv and fat_block_chain_manager_top_assert.svh.
`include "fat_block_chain_manager_top_assert.svh"

module fat_block_chain_manager_top #(
  parameter int NUM_BLOCKS = fbcm_pkg::NUM_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fbcm_in_if.sink   in_ch,
  fbcm_out_if.source out_ch
);

  localparam int AW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int EW  = $clog2(NUM_BLOCKS + 2);
  localparam int CTW = $clog2(NUM_BLOCKS + 1);
  localparam int CW  = ((CTW > fbcm_pkg::BLOCK_W) ? CTW : fbcm_pkg::BLOCK_W) + 1;

  localparam logic [EW-1:0]  ENT_EOC  = EW'(NUM_BLOCKS);
  localparam logic [EW-1:0]  ENT_FREE = EW'(NUM_BLOCKS + 1);
  localparam logic [CTW-1:0] N_CT     = CTW'(NUM_BLOCKS);
  localparam logic [CTW-1:0] LAST_CT  = CTW'(NUM_BLOCKS - 1);

  // Table RAM
  logic [EW-1:0] fat_mem [NUM_BLOCKS];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  fbcm_pkg::state_t state_r, state_nxt;

  logic [CTW-1:0] scan_r, scan_nxt;     // clear counter, alloc scan index
  logic [CTW-1:0] low_r, low_nxt;       // no free entry below this index
  logic [AW-1:0]  cur_r, cur_nxt;       // walk position / request block
  logic           has_r, has_nxt;       // request block is valid
  logic [CTW-1:0] steps_r, steps_nxt;
  logic [fbcm_pkg::COUNT_W-1:0]  freed_r, freed_nxt;
  logic [fbcm_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [fbcm_pkg::BLOCK_W-1:0]  res_blk_r, res_blk_nxt;
  logic [fbcm_pkg::KIND_W-1:0]   res_kind_r, res_kind_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [fbcm_pkg::STATUS_W-1:0] out_status_r;
  logic [fbcm_pkg::BLOCK_W-1:0]  out_blk_r;
  logic [fbcm_pkg::KIND_W-1:0]   out_kind_r;
  logic [fbcm_pkg::COUNT_W-1:0]  out_count_r;

  logic          in_xfer;
  logic          slot_free;
  logic          req_valid;
  logic [CW-1:0] req_blk_ext;
  logic          rd_is_free;
  logic          rd_is_ptr;
  logic          link_needed;

  assign in_ch.ready = (state_r == fbcm_pkg::S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign req_blk_ext = CW'(in_ch.block);
  assign req_valid   = in_ch.has_block && (req_blk_ext < CW'(NUM_BLOCKS));
  assign rd_is_free  = (rd_data_r == ENT_FREE);
  assign rd_is_ptr   = (rd_data_r < EW'(NUM_BLOCKS));
  assign link_needed = has_r && (CTW'(cur_r) != scan_r);

  // RAM: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fat_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= fat_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbcm_pkg::S_CLEAR: begin
        if (scan_r == LAST_CT) state_nxt = fbcm_pkg::S_IDLE;
      end
      fbcm_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (in_ch.op)
            fbcm_pkg::OP_ALLOC: state_nxt = fbcm_pkg::S_ALLOC_RD;
            fbcm_pkg::OP_FREE:
              state_nxt = req_valid ? fbcm_pkg::S_FREE_RD : fbcm_pkg::S_RESP;
            fbcm_pkg::OP_NEXT:
              state_nxt = req_valid ? fbcm_pkg::S_NEXT_RD : fbcm_pkg::S_RESP;
            default: state_nxt = fbcm_pkg::S_RESP;
          endcase
        end
      end
      fbcm_pkg::S_ALLOC_RD: begin
        state_nxt = (scan_r == N_CT) ? fbcm_pkg::S_RESP : fbcm_pkg::S_ALLOC_CHK;
      end
      fbcm_pkg::S_ALLOC_CHK: begin
        if (!rd_is_free) state_nxt = fbcm_pkg::S_ALLOC_RD;
        else if (link_needed) state_nxt = fbcm_pkg::S_ALLOC_LINK;
        else state_nxt = fbcm_pkg::S_RESP;
      end
      fbcm_pkg::S_ALLOC_LINK: state_nxt = fbcm_pkg::S_RESP;
      fbcm_pkg::S_FREE_RD:    state_nxt = fbcm_pkg::S_FREE_CHK;
      fbcm_pkg::S_FREE_CHK: begin
        if (rd_is_free || steps_r >= N_CT || !rd_is_ptr) state_nxt = fbcm_pkg::S_RESP;
        else state_nxt = fbcm_pkg::S_FREE_RD;
      end
      fbcm_pkg::S_NEXT_RD:  state_nxt = fbcm_pkg::S_NEXT_CHK;
      fbcm_pkg::S_NEXT_CHK: state_nxt = fbcm_pkg::S_RESP;
      fbcm_pkg::S_RESP: begin
        if (slot_free) state_nxt = fbcm_pkg::S_IDLE;
      end
      default: state_nxt = fbcm_pkg::S_CLEAR;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    scan_nxt       = scan_r;
    low_nxt        = low_r;
    cur_nxt        = cur_r;
    has_nxt        = has_r;
    steps_nxt      = steps_r;
    freed_nxt      = freed_r;
    res_status_nxt = res_status_r;
    res_blk_nxt    = res_blk_r;
    res_kind_nxt   = res_kind_r;
    rd_addr        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_data        = ENT_FREE;
    unique case (state_r)
      fbcm_pkg::S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = AW'(scan_r);
        wr_data  = ENT_FREE;
        scan_nxt = scan_r + 1'b1;
        low_nxt  = '0;
      end
      fbcm_pkg::S_IDLE: begin
        if (in_xfer) begin
          scan_nxt       = low_r;
          cur_nxt        = AW'(req_blk_ext);
          has_nxt        = req_valid;
          steps_nxt      = '0;
          freed_nxt      = '0;
          res_blk_nxt    = '0;
          res_kind_nxt   = fbcm_pkg::LK_POINTER;
          res_status_nxt = fbcm_pkg::ST_OK;
          if ((in_ch.op == fbcm_pkg::OP_FREE || in_ch.op == fbcm_pkg::OP_NEXT) &&
              !req_valid) begin
            res_status_nxt = fbcm_pkg::ST_NO_BLOCK;
          end
        end
      end
      fbcm_pkg::S_ALLOC_RD: begin
        rd_addr = AW'(scan_r);
        if (scan_r == N_CT) res_status_nxt = fbcm_pkg::ST_NO_SPACE;
      end
      fbcm_pkg::S_ALLOC_CHK: begin
        if (rd_is_free) begin
          // found: mark end of chain, keep scan_r as the new block
          wr_en       = 1'b1;
          wr_addr     = AW'(scan_r);
          wr_data     = ENT_EOC;
          low_nxt     = scan_r + 1'b1;
          res_blk_nxt = fbcm_pkg::BLOCK_W'(scan_r);
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      fbcm_pkg::S_ALLOC_LINK: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = EW'(scan_r);
      end
      fbcm_pkg::S_FREE_RD: begin
        rd_addr = cur_r;
      end
      fbcm_pkg::S_FREE_CHK: begin
        if (!rd_is_free) begin
          if (steps_r >= N_CT) begin
            res_status_nxt = fbcm_pkg::ST_LOOPED;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = cur_r;
            wr_data   = ENT_FREE;
            steps_nxt = steps_r + 1'b1;
            if (freed_r != fbcm_pkg::COUNT_MAX) freed_nxt = freed_r + 1'b1;
            if (CTW'(cur_r) < low_r) low_nxt = CTW'(cur_r);
            cur_nxt = AW'(rd_data_r);
          end
        end
      end
      fbcm_pkg::S_NEXT_RD: begin
        rd_addr = cur_r;
      end
      fbcm_pkg::S_NEXT_CHK: begin
        if (rd_is_free) begin
          res_kind_nxt = fbcm_pkg::LK_FREE;
        end else if (rd_is_ptr) begin
          res_kind_nxt = fbcm_pkg::LK_POINTER;
          res_blk_nxt  = fbcm_pkg::BLOCK_W'(rd_data_r);
        end else begin
          res_kind_nxt = fbcm_pkg::LK_EOC;
        end
      end
      fbcm_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == fbcm_pkg::S_RESP && slot_free) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbcm_pkg::S_CLEAR;
      scan_r      <= '0;
      low_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    has_r        <= has_nxt;
    steps_r      <= steps_nxt;
    freed_r      <= freed_nxt;
    res_status_r <= res_status_nxt;
    res_blk_r    <= res_blk_nxt;
    res_kind_r   <= res_kind_nxt;
    if (state_r == fbcm_pkg::S_RESP && slot_free) begin
      out_status_r <= res_status_r;
      out_blk_r    <= res_blk_r;
      out_kind_r   <= res_kind_r;
      out_count_r  <= freed_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_block = out_blk_r;
  assign out_ch.link_kind    = out_kind_r;
  assign out_ch.freed_count  = out_count_r;

  // Checks
  `FBCM_ASSERT_IMPL(a_scan_in_range, state_r == fbcm_pkg::S_ALLOC_CHK, scan_r < N_CT)
  `FBCM_ASSERT_IMPL(a_walk_bounded, state_r == fbcm_pkg::S_FREE_CHK, steps_r <= N_CT)
  `FBCM_ASSERT_IMPL(a_hint_in_range, state_r != fbcm_pkg::S_CLEAR, low_r <= N_CT)
  `FBCM_ASSERT_NEXT(a_accept_leaves_idle, in_xfer, state_r != fbcm_pkg::S_IDLE)
  `FBCM_ASSERT_IMPL(a_result_from_resp, $rose(out_valid_r),
                    $past(state_r) == fbcm_pkg::S_RESP)

endmodule

### bench/tb_fat_block_chain_manager_top.sv
// Self-checking bench for the FAT chain manager: drives requests, predicts
// every result from a shadow table and checks the result stream in order.
// Depends on fbcm_pkg, fbcm_if.sv and fat_block_chain_manager_top.sv.
module tb_fat_block_chain_manager_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = fbcm_pkg::NUM_BLOCKS_DEF;
  localparam logic [fbcm_pkg::COUNT_W-1:0] ENT_EOC  = fbcm_pkg::COUNT_W'(NB);
  localparam logic [fbcm_pkg::COUNT_W-1:0] ENT_FREE = fbcm_pkg::COUNT_W'(NB + 1);
  localparam logic [fbcm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 12_000_000;
  localparam int RANDOM_REQS = 360;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [fbcm_pkg::OP_W-1:0]    op;
    logic [fbcm_pkg::BLOCK_W-1:0] block;
    logic                         has_block;
  } fat_req_t;

  typedef struct packed {
    logic [fbcm_pkg::STATUS_W-1:0] status;
    logic [fbcm_pkg::BLOCK_W-1:0]  result_block;
    logic [fbcm_pkg::KIND_W-1:0]   link_kind;
    logic [fbcm_pkg::COUNT_W-1:0]  freed_count;
  } fat_res_t;

  logic clk;
  logic rst_n;

  fbcm_in_if  req_if ();
  fbcm_out_if res_if ();

  fat_block_chain_manager_top #(.NUM_BLOCKS(NB)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  // Shadow table and what the predictor knows about chains
  logic [fbcm_pkg::COUNT_W-1:0] fat_shadow [NB];
  int       chain_heads[$];
  int       last_alloc;
  fat_req_t req_q[$];
  fat_res_t results_due[$];
  fat_req_t drv_item;
  fat_res_t got_res;
  fat_res_t exp_res;
  bit       req_taken;
  bit       calm;
  bit       held;
  int       hold_left;
  int       reqs_taken;
  int       results_seen;
  int       errors;
  longint   cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the shadow table and return the result it gives
  function automatic fat_res_t fat_apply(fat_req_t rq);
    fat_res_t r;
    int found;
    int cur;
    int steps;
    int freed;
    bit done;
    bit looped;
    logic [fbcm_pkg::COUNT_W-1:0] nxt;
    r = '0;
    found = -1;
    cur = 0;
    steps = 0;
    freed = 0;
    done = 1'b0;
    looped = 1'b0;
    case (rq.op)
      fbcm_pkg::OP_ALLOC: begin
        for (int i = 0; i < NB && found < 0; i++)
          if (fat_shadow[i] == ENT_FREE) found = i;
        if (found < 0) begin
          r.status = fbcm_pkg::ST_NO_SPACE;
        end else begin
          // link first, then the end mark, so a self tail ends as end-of-chain
          if (rq.has_block) fat_shadow[rq.block] = fbcm_pkg::COUNT_W'(found);
          else chain_heads.push_back(found);
          fat_shadow[found] = ENT_EOC;
          last_alloc = found;
          r.result_block = fbcm_pkg::BLOCK_W'(found);
        end
      end
      fbcm_pkg::OP_FREE: begin
        if (!rq.has_block) begin
          r.status = fbcm_pkg::ST_NO_BLOCK;
        end else begin
          cur = int'(rq.block);
          while (!done) begin
            nxt = fat_shadow[cur];
            if (nxt == ENT_FREE) begin
              done = 1'b1;
            end else if (steps >= NB) begin
              looped = 1'b1;
              done = 1'b1;
            end else begin
              fat_shadow[cur] = ENT_FREE;
              steps++;
              if (freed < int'(fbcm_pkg::COUNT_MAX)) freed++;
              if (nxt >= ENT_EOC) done = 1'b1;
              else cur = int'(nxt);
            end
          end
          if (looped) r.status = fbcm_pkg::ST_LOOPED;
          r.freed_count = fbcm_pkg::COUNT_W'(freed);
        end
      end
      fbcm_pkg::OP_NEXT: begin
        if (!rq.has_block) r.status = fbcm_pkg::ST_NO_BLOCK;
        else if (fat_shadow[rq.block] == ENT_FREE) r.link_kind = fbcm_pkg::LK_FREE;
        else if (fat_shadow[rq.block] == ENT_EOC) r.link_kind = fbcm_pkg::LK_EOC;
        else r.result_block = fbcm_pkg::BLOCK_W'(fat_shadow[rq.block]);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int free_count_now();
    int n;
    n = 0;
    for (int i = 0; i < NB; i++)
      if (fat_shadow[i] == ENT_FREE) n++;
    return n;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < NB; i++)
      if (fat_shadow[i] == ENT_FREE) return i;
    return 0;
  endfunction

  // A block that is in some chain, if a few probes find one
  function automatic int any_used_block();
    int b;
    b = $urandom_range(NB - 1);
    for (int t = 0; t < 24; t++) begin
      if (fat_shadow[b] != ENT_FREE) return b;
      b = $urandom_range(NB - 1);
    end
    return b;
  endfunction

  // Queue a request; keep only a short backlog so choices track the table
  task automatic push_req(logic [fbcm_pkg::OP_W-1:0] op, int blk, bit has);
    fat_req_t rq;
    rq.op = op;
    rq.block = fbcm_pkg::BLOCK_W'(blk);
    rq.has_block = has;
    while (req_q.size() >= 2) @(posedge clk);
    req_q.push_back(rq);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (req_q.size() != 0 || req_if.valid || results_due.size() != 0);
  endtask

  // One random request, mostly aimed at live chains
  task automatic gen_random_req();
    int sel;
    int k;
    int b;
    int idx;
    int alloc_w;
    int free_w;
    bit h;
    logic [fbcm_pkg::OP_W-1:0] op;
    sel = $urandom_range(99);
    k = $urandom_range(99);
    b = $urandom_range(NB - 1);
    h = 1'b1;
    alloc_w = (free_count_now() < 150) ? 15 : 40;
    free_w  = (free_count_now() < 150) ? 45 : 18;
    if (sel < alloc_w) begin
      op = fbcm_pkg::OP_ALLOC;
      if (k < 50) b = last_alloc;
      else if (k < 70) b = any_used_block();
      else if (k < 80) b = lowest_free();
      else if (k < 90) h = 1'b0;
    end else if (sel < alloc_w + free_w) begin
      op = fbcm_pkg::OP_FREE;
      if (k < 55 && chain_heads.size() > 0) begin
        idx = $urandom_range(chain_heads.size() - 1);
        b = chain_heads[idx];
        chain_heads.delete(idx);
      end else if (k < 80) begin
        b = any_used_block();
      end else if (k >= 90) begin
        h = 1'b0;
      end
    end else if (sel < alloc_w + free_w + 33) begin
      op = fbcm_pkg::OP_NEXT;
      if (k < 60) b = any_used_block();
      else if (k >= 85) h = 1'b0;
    end else begin
      op = OP_UNUSED;
      h = 1'($urandom_range(1));
    end
    push_req(op, b, h);
  endtask

  // Stimulus: directed cases, random mix, release of the open chains, then more random requests
  initial begin
    rst_n = 1'b0;
    last_alloc = 0;
    for (int i = 0; i < NB; i++) fat_shadow[i] = ENT_FREE;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    push_req(fbcm_pkg::OP_NEXT, 0, 1'b1);
    push_req(fbcm_pkg::OP_NEXT, 1023, 1'b0);
    push_req(fbcm_pkg::OP_FREE, 1023, 1'b0);
    push_req(fbcm_pkg::OP_FREE, 5, 1'b1);          // start already free
    push_req(fbcm_pkg::OP_ALLOC, 0, 1'b0);         // no tail
    push_req(fbcm_pkg::OP_ALLOC, 0, 1'b1);
    push_req(fbcm_pkg::OP_NEXT, 0, 1'b1);
    push_req(fbcm_pkg::OP_NEXT, 1, 1'b1);
    push_req(fbcm_pkg::OP_ALLOC, 2, 1'b1);         // tail is the block being handed out
    push_req(fbcm_pkg::OP_NEXT, 2, 1'b1);
    push_req(fbcm_pkg::OP_ALLOC, 1023, 1'b1);      // tail entry was free, gets overwritten
    push_req(fbcm_pkg::OP_NEXT, 1023, 1'b1);
    push_req(fbcm_pkg::OP_FREE, 1023, 1'b1);
    push_req(fbcm_pkg::OP_FREE, 0, 1'b1);
    push_req(OP_UNUSED, 1023, 1'b1);
    push_req(OP_UNUSED, 0, 1'b0);
    push_req(fbcm_pkg::OP_NEXT, 1023, 1'b1);
    push_req(fbcm_pkg::OP_ALLOC, 2, 1'b1);         // tail already end-of-chain
    push_req(fbcm_pkg::OP_FREE, 2, 1'b1);
    push_req(fbcm_pkg::OP_ALLOC, 1023, 1'b0);
    push_req(fbcm_pkg::OP_FREE, 1023, 1'b0);
    push_req(fbcm_pkg::OP_NEXT, 512, 1'b1);

    repeat (RANDOM_REQS) gen_random_req();

    // free the chains that were started without a tail
    while (chain_heads.size() > 0)
      push_req(fbcm_pkg::OP_FREE, chain_heads.pop_front(), 1'b1);
    repeat (20) gen_random_req();

    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_fat_block_chain_manager_top: done, clean");
    end else begin
      $display("tb_fat_block_chain_manager_top: done, errors");
    end
    $finish;
  end

  // no idling on either side for a stretch of transfers
  assign calm = (reqs_taken >= 150) && (reqs_taken < 260);

  // Request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid     <= 1'b0;
      req_if.op        <= '0;
      req_if.block     <= '0;
      req_if.has_block <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (req_q.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
        drv_item = req_q.pop_front();
        req_if.valid     <= 1'b1;
        req_if.op        <= drv_item.op;
        req_if.block     <= drv_item.block;
        req_if.has_block <= drv_item.has_block;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off so the block backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (!held && results_seen >= 120) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  // Prediction on request transfers, checking on result transfers
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_fat_block_chain_manager_top: done, errors");
      $finish;
    end else begin
      req_taken = rst_n && req_if.valid && req_if.ready;
      if (req_taken) begin
        results_due.push_back(fat_apply({req_if.op, req_if.block, req_if.has_block}));
        reqs_taken++;
      end
      if (rst_n && res_if.valid && res_if.ready) begin
        got_res = {res_if.status, res_if.result_block, res_if.link_kind,
                   res_if.freed_count};
        results_seen++;
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: status %0d block %0d kind %0d count %0d",
                   $time, got_res.status, got_res.result_block, got_res.link_kind,
                   got_res.freed_count);
        end else begin
          exp_res = results_due.pop_front();
          if (got_res !== exp_res) begin
            errors++;
            $display({"%0t: mismatch: expected status %0d block %0d kind %0d count %0d,",
                      " got status %0d block %0d kind %0d count %0d"},
                     $time, exp_res.status, exp_res.result_block, exp_res.link_kind,
                     exp_res.freed_count, got_res.status, got_res.result_block,
                     got_res.link_kind, got_res.freed_count);
          end
        end
      end
    end
  end

endmodule
